/* rtl/core/tfna_pkg.sv */
// shared types and constants for the triangle face normal and area block
`default_nettype none

package tfna_pkg;

  localparam int TAG_W      = 20;
  localparam int COORD_W    = 24;
  localparam int NORMAL_W   = 16;
  localparam int AREA_W     = 49;
  localparam int THRESH_W   = 40;
  localparam int STATUS_W   = 2;
  localparam int NUM_AXES   = 3;
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 4;
  localparam int CMP_W      = 64;

  // register index is the 8-byte word number, taken from the top address bit
  localparam logic [0:0] REG_MIN_CROSS_LENGTH = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_UPDATED    = 2'd0,
    STATUS_DEGENERATE = 2'd1,
    STATUS_SKIPPED    = 2'd2
  } tfna_status_e;

  // control travelling alongside each item through the cells
  typedef struct packed {
    logic             valid;
    logic             links;
    logic [TAG_W-1:0] tag;
  } tfna_side_t;

  typedef struct packed {
    logic [TAG_W-1:0]                   tag;
    logic                               links;
    logic [NUM_AXES-1:0][COORD_W-1:0]   corner;
    logic [NUM_AXES-1:0][COORD_W-1:0]   prev;
    logic [NUM_AXES-1:0][COORD_W-1:0]   next;
  } tfna_item_t;

endpackage

`default_nettype wire

/* rtl/core/tfna_if.sv */
// item channel interfaces: triangle in, normal and area out
`default_nettype none

interface tfna_in_if;
  import tfna_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [TAG_W-1:0]          face_tag;
  logic                      links_complete;
  logic signed [COORD_W-1:0] corner_x;
  logic signed [COORD_W-1:0] corner_y;
  logic signed [COORD_W-1:0] corner_z;
  logic signed [COORD_W-1:0] prev_x;
  logic signed [COORD_W-1:0] prev_y;
  logic signed [COORD_W-1:0] prev_z;
  logic signed [COORD_W-1:0] next_x;
  logic signed [COORD_W-1:0] next_y;
  logic signed [COORD_W-1:0] next_z;

  modport source (
    output valid, face_tag, links_complete, corner_x, corner_y, corner_z,
           prev_x, prev_y, prev_z, next_x, next_y, next_z,
    input  ready
  );
  modport sink (
    input  valid, face_tag, links_complete, corner_x, corner_y, corner_z,
           prev_x, prev_y, prev_z, next_x, next_y, next_z,
    output ready
  );
endinterface

interface tfna_out_if;
  import tfna_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [TAG_W-1:0]           result_tag;
  logic [STATUS_W-1:0]        status;
  logic [AREA_W-1:0]          area;
  logic signed [NORMAL_W-1:0] normal_x;
  logic signed [NORMAL_W-1:0] normal_y;
  logic signed [NORMAL_W-1:0] normal_z;

  modport source (
    output valid, result_tag, status, area, normal_x, normal_y, normal_z,
    input  ready
  );
  modport sink (
    input  valid, result_tag, status, area, normal_x, normal_y, normal_z,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/tfna_sqrt_cell.sv */
// one restoring square root cell: settles a single root bit
`default_nettype none

module tfna_sqrt_cell #(
  parameter int SW  = 102,
  parameter int LW  = 51,
  parameter int BIT = 0,
  parameter int DW  = 153
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  tfna_pkg::tfna_side_t side_i,
  input  logic [SW-1:0]        rem_i,
  input  logic [LW-1:0]        root_i,
  input  logic [DW-1:0]        data_i,
  output tfna_pkg::tfna_side_t side_o,
  output logic [SW-1:0]        rem_o,
  output logic [LW-1:0]        root_o,
  output logic [DW-1:0]        data_o
);
  import tfna_pkg::*;

  logic [SW:0]   trial;
  logic          take;
  logic [SW-1:0] rem_d;
  logic [LW-1:0] root_d;
  tfna_side_t    side_q;
  logic [SW-1:0] rem_q;
  logic [LW-1:0] root_q;
  logic [DW-1:0] data_q;

  // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
  always_comb begin
    trial  = ((SW+1)'(root_i) << (BIT + 1)) + ((SW+1)'(1) << (2 * BIT));
    take   = {1'b0, rem_i} >= trial;
    rem_d  = take ? SW'({1'b0, rem_i} - trial) : rem_i;
    root_d = take ? (root_i | (LW'(1) << BIT)) : root_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      data_q <= data_i;
    end
  end

  assign side_o = side_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

/* rtl/core/tfna_div_cell.sv */
// one restoring division cell: one quotient bit for each axis
`default_nettype none

module tfna_div_cell #(
  parameter int LW    = 51,
  parameter int RW    = 52,
  parameter int QW    = 16,
  parameter bit FIRST = 1'b0
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  tfna_pkg::tfna_side_t                       side_i,
  input  logic [LW-1:0]                              len_i,
  input  logic [tfna_pkg::NUM_AXES-1:0]              sgn_i,
  input  logic [tfna_pkg::NUM_AXES-1:0][RW-1:0]      rem_i,
  input  logic [tfna_pkg::NUM_AXES-1:0][QW-1:0]      quo_i,
  output tfna_pkg::tfna_side_t                       side_o,
  output logic [LW-1:0]                              len_o,
  output logic [tfna_pkg::NUM_AXES-1:0]              sgn_o,
  output logic [tfna_pkg::NUM_AXES-1:0][RW-1:0]      rem_o,
  output logic [tfna_pkg::NUM_AXES-1:0][QW-1:0]      quo_o
);
  import tfna_pkg::*;

  logic [NUM_AXES-1:0][RW-1:0] shifted;
  logic [NUM_AXES-1:0]         ge;
  logic [NUM_AXES-1:0][RW-1:0] rem_d;
  logic [NUM_AXES-1:0][QW-1:0] quo_d;
  tfna_side_t                  side_q;
  logic [LW-1:0]               len_q;
  logic [NUM_AXES-1:0]         sgn_q;
  logic [NUM_AXES-1:0][RW-1:0] rem_q;
  logic [NUM_AXES-1:0][QW-1:0] quo_q;

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      shifted[k] = FIRST ? rem_i[k] : {rem_i[k][RW-2:0], 1'b0};
      ge[k]      = shifted[k] >= RW'(len_i);
      rem_d[k]   = ge[k] ? (shifted[k] - RW'(len_i)) : shifted[k];
      quo_d[k]   = {quo_i[k][QW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q <= len_i;
      sgn_q <= sgn_i;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign side_o = side_q;
  assign len_o  = len_q;
  assign sgn_o  = sgn_q;
  assign rem_o  = rem_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

/* rtl/core/triangle_face_normal_area.sv */
// top level: triangle face normal and area, fully pipelined row of cells
`default_nettype none

// Takes one triangle per cycle and returns one result per triangle, in order.
// The edge vectors u = prev - corner and v = next - corner are crossed, the
// squared length of the cross product is built from split partial squares,
// then a row of 2*COORD_BITS+3 square root cells settles the length one bit
// per cell, and a row of NORMAL_BITS division cells forms the three unit
// normal components in parallel lanes. The pipeline is six front stages, the
// root cells, the divide cells and the output register. Throughput is one item
// per cycle, limited by nothing but the output handshake; a one-item skid
// buffer in front keeps the input ready a plain register, so a result waiting
// at the output still lets one more item in. The min_cross_length register is
// at byte address 0 of the APB port and should only be written while no item
// is in flight.
module triangle_face_normal_area #(
  parameter int COORD_BITS  = 24,
  parameter int NORMAL_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tfna_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tfna_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tfna_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  tfna_in_if.sink                         item_i,
  tfna_out_if.source                      result_o
);
  import tfna_pkg::*;

  // widths of the datapath, all but the quotient width following from the coordinate width
  localparam int CW  = COORD_BITS;
  localparam int UW  = CW + 1;         // edge vector component
  localparam int PW  = 2 * UW;         // one cross term
  localparam int NW  = PW + 1;         // cross component, signed
  localparam int MW  = NW - 1;         // cross component magnitude
  localparam int HW  = (MW + 1) / 2;   // low half for squaring
  localparam int HIW = MW - HW;        // high half for squaring
  localparam int SW  = 2 * MW + 2;     // sum of squares
  localparam int LW  = MW + 1;         // root bits
  localparam int RW  = LW + 1;         // divider remainder
  localparam int QW  = NORMAL_BITS;    // quotient bits
  localparam int DW  = NUM_AXES * (MW + 1);

  // ---------------------------------------------------------------- config
  logic [THRESH_W-1:0] min_len_q;
  logic                cfg_hit;

  assign cfg_hit = paddr[APB_ADDR_W-1] == REG_MIN_CROSS_LENGTH;
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? APB_DATA_W'(min_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= '0;
    end else if (psel && penable && pwrite && cfg_hit) begin
      min_len_q <= pwdata[THRESH_W-1:0];
    end
  end

  // --------------------------------------------------- stall and skid item
  // the whole row moves together whenever the output register can take data
  logic       out_valid_q;
  logic       en;
  logic       in_acc;
  logic       skid_v_q;
  logic       skid_v_d;
  tfna_item_t skid_q;
  tfna_item_t item_in;
  tfna_item_t pipe_in;
  logic       pipe_in_v;

  assign en            = !out_valid_q || result_o.ready;
  assign item_i.ready  = !skid_v_q;
  assign in_acc        = item_i.valid && !skid_v_q;

  always_comb begin
    item_in.tag       = item_i.face_tag;
    item_in.links     = item_i.links_complete;
    item_in.corner[0] = item_i.corner_x;
    item_in.corner[1] = item_i.corner_y;
    item_in.corner[2] = item_i.corner_z;
    item_in.prev[0]   = item_i.prev_x;
    item_in.prev[1]   = item_i.prev_y;
    item_in.prev[2]   = item_i.prev_z;
    item_in.next[0]   = item_i.next_x;
    item_in.next[1]   = item_i.next_y;
    item_in.next[2]   = item_i.next_z;
  end

  // skid fills only when an item arrives into a stalled row
  assign skid_v_d  = skid_v_q ? !en : (in_acc && !en);
  assign pipe_in   = skid_v_q ? skid_q : item_in;
  assign pipe_in_v = skid_v_q || in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !en) begin
      skid_q <= item_in;
    end
  end

  // ----------------------------------------------------------- front stages
  tfna_side_t side_a_q, side_b_q, side_c_q, side_d_q, side_e_q, side_f_q;
  tfna_side_t side_in;

  logic signed [UW-1:0] u_d [NUM_AXES];
  logic signed [UW-1:0] v_d [NUM_AXES];
  logic signed [UW-1:0] u_q [NUM_AXES];
  logic signed [UW-1:0] v_q [NUM_AXES];
  logic signed [PW-1:0] prod_q [2*NUM_AXES];
  logic signed [NW-1:0] cross_d [NUM_AXES];

  logic [NUM_AXES-1:0]          sgn_c_q, sgn_d_q, sgn_e_q, sgn_f_q;
  logic [NUM_AXES-1:0][MW-1:0]  mag_c_q, mag_d_q, mag_e_q, mag_f_q;
  logic [NUM_AXES-1:0][MW-1:0]  mag_c_d;

  logic [2*HW-1:0]      sq_lo_q  [NUM_AXES];
  logic [HIW+HW-1:0]    sq_mid_q [NUM_AXES];
  logic [2*HIW-1:0]     sq_hi_q  [NUM_AXES];
  logic [SW-1:0]        sq_q     [NUM_AXES];
  logic [SW-1:0]        sum_q;

  assign side_in = '{valid: pipe_in_v, links: pipe_in.links, tag: pipe_in.tag};

  // edge vectors from the low COORD_BITS of each coordinate, sign extended
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      u_d[k] = $signed({pipe_in.prev[k][CW-1], pipe_in.prev[k][CW-1:0]})
             - $signed({pipe_in.corner[k][CW-1], pipe_in.corner[k][CW-1:0]});
      v_d[k] = $signed({pipe_in.next[k][CW-1], pipe_in.next[k][CW-1:0]})
             - $signed({pipe_in.corner[k][CW-1], pipe_in.corner[k][CW-1:0]});
    end
  end

  // cross components, then sign and magnitude
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      cross_d[k] = NW'(prod_q[2*k]) - NW'(prod_q[2*k+1]);
      mag_c_d[k] = MW'(cross_d[k][NW-1] ? -cross_d[k] : cross_d[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_a_q <= '0;
      side_b_q <= '0;
      side_c_q <= '0;
      side_d_q <= '0;
      side_e_q <= '0;
      side_f_q <= '0;
    end else if (en) begin
      side_a_q <= side_in;
      side_b_q <= side_a_q;
      side_c_q <= side_b_q;
      side_d_q <= side_c_q;
      side_e_q <= side_d_q;
      side_f_q <= side_e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        u_q[k] <= u_d[k];
        v_q[k] <= v_d[k];
      end
      // n = u x v, one product per register
      prod_q[0] <= PW'(u_q[1]) * PW'(v_q[2]);
      prod_q[1] <= PW'(u_q[2]) * PW'(v_q[1]);
      prod_q[2] <= PW'(u_q[2]) * PW'(v_q[0]);
      prod_q[3] <= PW'(u_q[0]) * PW'(v_q[2]);
      prod_q[4] <= PW'(u_q[0]) * PW'(v_q[1]);
      prod_q[5] <= PW'(u_q[1]) * PW'(v_q[0]);
      for (int k = 0; k < NUM_AXES; k++) begin
        sgn_c_q[k]  <= cross_d[k][NW-1];
        mag_c_q[k]  <= mag_c_d[k];
        // square split into halves to keep each multiplier narrow
        sq_lo_q[k]  <= (2*HW)'(mag_c_q[k][HW-1:0]) * (2*HW)'(mag_c_q[k][HW-1:0]);
        sq_mid_q[k] <= (HIW+HW)'(mag_c_q[k][MW-1:HW]) * (HIW+HW)'(mag_c_q[k][HW-1:0]);
        sq_hi_q[k]  <= (2*HIW)'(mag_c_q[k][MW-1:HW]) * (2*HIW)'(mag_c_q[k][MW-1:HW]);
        sq_q[k]     <= (SW'(sq_hi_q[k]) << (2 * HW)) + (SW'(sq_mid_q[k]) << (HW + 1))
                     + SW'(sq_lo_q[k]);
      end
      sgn_d_q <= sgn_c_q;
      mag_d_q <= mag_c_q;
      sgn_e_q <= sgn_d_q;
      mag_e_q <= mag_d_q;
      sgn_f_q <= sgn_e_q;
      mag_f_q <= mag_e_q;
      sum_q   <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  // ------------------------------------------------------- square root row
  tfna_side_t    side_s [LW+1];
  logic [SW-1:0] rem_s  [LW+1];
  logic [LW-1:0] root_s [LW+1];
  logic [DW-1:0] data_s [LW+1];

  assign side_s[0] = side_f_q;
  assign rem_s[0]  = sum_q;
  assign root_s[0] = '0;
  assign data_s[0] = {sgn_f_q, mag_f_q};

  for (genvar i = 0; i < LW; i++) begin : g_sqrt
    tfna_sqrt_cell #(
      .SW  (SW),
      .LW  (LW),
      .BIT (LW - 1 - i),
      .DW  (DW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .side_i (side_s[i]),
      .rem_i  (rem_s[i]),
      .root_i (root_s[i]),
      .data_i (data_s[i]),
      .side_o (side_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .root_o (root_s[i+1]),
      .data_o (data_s[i+1])
    );
  end

  // ---------------------------------------------------------- division row
  tfna_side_t                  side_v [QW+1];
  logic [LW-1:0]               len_v  [QW+1];
  logic [NUM_AXES-1:0]         sgn_v  [QW+1];
  logic [NUM_AXES-1:0][RW-1:0] rem_v  [QW+1];
  logic [NUM_AXES-1:0][QW-1:0] quo_v  [QW+1];
  logic [NUM_AXES-1:0][MW-1:0] mag_root;

  assign side_v[0] = side_s[LW];
  assign len_v[0]  = root_s[LW];
  assign sgn_v[0]  = data_s[LW][DW-1 -: NUM_AXES];
  assign mag_root  = data_s[LW][NUM_AXES*MW-1:0];
  assign quo_v[0]  = '0;

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      rem_v[0][k] = RW'(mag_root[k]);
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    tfna_div_cell #(
      .LW    (LW),
      .RW    (RW),
      .QW    (QW),
      .FIRST (i == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .side_i (side_v[i]),
      .len_i  (len_v[i]),
      .sgn_i  (sgn_v[i]),
      .rem_i  (rem_v[i]),
      .quo_i  (quo_v[i]),
      .side_o (side_v[i+1]),
      .len_o  (len_v[i+1]),
      .sgn_o  (sgn_v[i+1]),
      .rem_o  (rem_v[i+1]),
      .quo_o  (quo_v[i+1])
    );
  end

  // ------------------------------------------------ rounding and output reg
  tfna_side_t            side_end;
  logic [LW-1:0]         len_end;
  logic [QW:0]           cap;
  logic [QW:0]           q_round [NUM_AXES];
  logic [QW:0]           q_cap   [NUM_AXES];
  logic signed [QW-1:0]  comp    [NUM_AXES];
  logic                  degen;
  tfna_status_e          status_d;
  logic [AREA_W-1:0]     area_d;
  logic signed [NORMAL_W-1:0] norm_d [NUM_AXES];

  tfna_status_e               status_q;
  logic [TAG_W-1:0]           tag_q;
  logic [AREA_W-1:0]          area_q;
  logic signed [NORMAL_W-1:0] norm_q [NUM_AXES];

  assign side_end = side_v[QW];
  assign len_end  = len_v[QW];
  assign cap      = ((QW+1)'(1) << (QW - 1)) - (QW+1)'(1);
  assign degen    = CMP_W'(len_end) <= CMP_W'(min_len_q);

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      // round half away from zero on the magnitude, then saturate
      q_round[k] = (QW+1)'(quo_v[QW][k])
                 + (QW+1)'({rem_v[QW][k], 1'b0} >= (RW+1)'(len_end));
      q_cap[k]   = (q_round[k] > cap) ? cap : q_round[k];
      comp[k]    = sgn_v[QW][k] ? -$signed(q_cap[k][QW-1:0])
                                : $signed(q_cap[k][QW-1:0]);
    end
    area_d   = AREA_W'(len_end >> 1);
    status_d = STATUS_UPDATED;
    for (int k = 0; k < NUM_AXES; k++) begin
      norm_d[k] = NORMAL_W'(comp[k]);
    end
    if (!side_end.links) begin
      status_d = STATUS_SKIPPED;
      area_d   = '0;
      for (int k = 0; k < NUM_AXES; k++) begin
        norm_d[k] = '0;
      end
    end else if (degen) begin
      status_d = STATUS_DEGENERATE;
      for (int k = 0; k < NUM_AXES; k++) begin
        norm_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= side_end.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag_q    <= side_end.tag;
      status_q <= status_d;
      area_q   <= area_d;
      for (int k = 0; k < NUM_AXES; k++) begin
        norm_q[k] <= norm_d[k];
      end
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.result_tag = tag_q;
  assign result_o.status     = status_q;
  assign result_o.area       = area_q;
  assign result_o.normal_x   = norm_q[0];
  assign result_o.normal_y   = norm_q[1];
  assign result_o.normal_z   = norm_q[2];

endmodule

`default_nettype wire

/* rtl/core/tfna_checker.sv */
// port-level checks on the result channel, bound to the top level
`default_nettype none

module tfna_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [tfna_pkg::TAG_W-1:0]      tag_i,
  input logic [tfna_pkg::STATUS_W-1:0]   status_i,
  input logic [tfna_pkg::AREA_W-1:0]     area_i,
  input logic [tfna_pkg::NORMAL_W-1:0]   normal_x_i,
  input logic [tfna_pkg::NORMAL_W-1:0]   normal_y_i,
  input logic [tfna_pkg::NORMAL_W-1:0]   normal_z_i
);
  import tfna_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(tag_i)
      && $stable(status_i) && $stable(area_i))
    else $error("stalled result changed");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i == STATUS_UPDATED || status_i == STATUS_DEGENERATE
      || status_i == STATUS_SKIPPED)
    else $error("status code out of range");

  a_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STATUS_SKIPPED |-> area_i == '0
      && normal_x_i == '0 && normal_y_i == '0 && normal_z_i == '0)
    else $error("skipped item carries values");

  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STATUS_DEGENERATE |-> normal_x_i == '0
      && normal_y_i == '0 && normal_z_i == '0)
    else $error("degenerate item carries a normal");

endmodule

bind triangle_face_normal_area tfna_checker u_tfna_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(result_o.valid),
  .out_ready_i(result_o.ready),
  .tag_i      (result_o.result_tag),
  .status_i   (result_o.status),
  .area_i     (result_o.area),
  .normal_x_i (result_o.normal_x),
  .normal_y_i (result_o.normal_y),
  .normal_z_i (result_o.normal_z)
);

`default_nettype wire
